[rtl/core/ffpa_pkg.sv]
package ffpa_pkg;
  localparam int RECORD_SLOTS = 1024;
  localparam int IDX_W = $clog2(RECORD_SLOTS);
  localparam int CNT_W = $clog2(RECORD_SLOTS + 1);
  localparam int REC_W = 97;  // offset, capacity, used, free flag

  localparam logic [31:0] POOL_SIZE_RESET = 32'd1048576;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] capacity;
    logic [31:0] used;
    logic        is_free;
  } rec_t;
endpackage

[rtl/core/ffpa_ram.sv]
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[rtl/core/first_fit_pool_allocator.sv]
// Scan: each record is read, then evaluated (S_READ, then S_EVAL). A hit goes on to
// S_OUT, a split first writes the tail record in S_APP and then goes to S_OUT, and a
// miss over all records goes from S_READ straight to S_OUT.
// Throughput: one request at a time; the input stalls until the result transaction
// is taken, so the scan length sets the rate.
// Reset: synchronous active-low clears count and bump pointer, pool size back to 1 MiB.
module first_fit_pool_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_alloc_size,
  input  logic [31:0] in_free_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_granted_offset,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import ffpa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_APP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [31:0]      pool_size_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      bump_r, bump_nxt;
  logic             cmd_r;
  logic [31:0]      size_r, foff_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [31:0]      res_off_r, res_off_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  rec_t             app_r, app_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_data, rd_data;
  logic [IDX_W-1:0] rd_addr;

  ffpa_ram #(.WIDTH(REC_W), .DEPTH(RECORD_SLOTS)) u_tab (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign rd_addr   = idx_r[IDX_W-1:0];
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_granted_offset = res_off_r;
  assign out_status = res_st_r;

  logic [31:0] slack;
  logic [32:0] bump_sum;
  logic        full;
  assign slack    = rd_data.capacity - rd_data.used;
  assign bump_sum = {1'b0, bump_r} + {1'b0, size_r};
  assign full     = (count_r == CNT_W'(RECORD_SLOTS));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    bump_nxt = bump_r;
    idx_nxt = idx_r;
    res_off_nxt = res_off_r;
    res_st_nxt = res_st_r;
    app_nxt = app_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en = 1'b0;
    wr_addr = idx_r[IDX_W-1:0];
    wr_data = rd_data;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          idx_nxt = '0;
          res_off_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // read of entry idx_r issued; nothing left means the scan missed
        if (idx_r == count_r) begin
          if (cmd_r == CMD_FREE) begin
            res_st_nxt = ST_NOT_FOUND;
          end else if (bump_sum > {1'b0, pool_size_r}) begin
            res_st_nxt = ST_EXHAUSTED;
          end else if (full) begin
            res_st_nxt = ST_TABLE_FULL;
          end else begin
            wr_en = 1'b1;
            wr_addr = count_r[IDX_W-1:0];
            wr_data = '{offset: bump_r, capacity: size_r, used: size_r, is_free: 1'b0};
            count_nxt = count_r + 1'b1;
            bump_nxt = bump_sum[31:0];
            res_off_nxt = bump_r;
            res_st_nxt = ST_OK;
          end
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_READ;
        idx_nxt = idx_r + 1'b1;
        if (cmd_r == CMD_FREE) begin
          if (rd_data.offset == foff_r) begin
            wr_en = 1'b1;
            wr_data.is_free = 1'b1;
            wr_data.used = '0;
            res_st_nxt = ST_OK;
            state_nxt = S_OUT;
          end
        end else if (rd_data.is_free && rd_data.capacity >= size_r) begin
          wr_en = 1'b1;
          wr_data.is_free = 1'b0;
          wr_data.used = size_r;
          res_off_nxt = rd_data.offset;
          res_st_nxt = ST_OK;
          state_nxt = S_OUT;
        end else if (slack >= size_r) begin
          if (full) begin
            res_st_nxt = ST_TABLE_FULL;
            state_nxt = S_OUT;
          end else begin
            wr_en = 1'b1;
            wr_data.capacity = rd_data.used;
            app_nxt = '{offset: rd_data.offset + rd_data.used, capacity: slack,
                        used: size_r, is_free: 1'b0};
            res_off_nxt = rd_data.offset + rd_data.used;
            res_st_nxt = ST_OK;
            state_nxt = S_APP;
          end
        end
      end
      S_APP: begin
        wr_en = 1'b1;
        wr_addr = count_r[IDX_W-1:0];
        wr_data = app_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      bump_r <= '0;
      pool_size_r <= POOL_SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bump_r <= bump_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        pool_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      cmd_r <= in_cmd;
      size_r <= in_alloc_size;
      foff_r <= in_free_offset;
    end
    idx_r <= idx_nxt;
    res_off_r <= res_off_nxt;
    res_st_r <= res_st_nxt;
    app_r <= app_nxt;
  end
endmodule
